[src/vlc_pkg.sv]
// vlc_pkg: shared types, codes and sizes of the vector/lamport clock block
// used by vlc_ctrl, vlc_datapath and vector_lamport_clock_core; no dependencies
package vlc_pkg;

   // default sizes handed to the top level parameters
   localparam int DEF_MAX_PROCESSES = 16;
   localparam int DEF_CLOCK_WIDTH   = 32;

   // fixed field widths of the ports
   localparam int KIND_W  = 2;
   localparam int SLOT_W  = 6;
   localparam int FIELD_W = 32;
   localparam int OWN_W   = 6;
   localparam int ACT_W   = 7;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_INDEX    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_COUNT = 2'd1;

   // register reset values
   localparam logic [OWN_W-1:0] OWN_INDEX_RESET    = 6'd1;
   localparam logic [ACT_W-1:0] ACTIVE_COUNT_RESET = 7'd16;

   // item kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_LOCAL  = 2'd0,
      KIND_SEND   = 2'd1,
      KIND_RECV   = 2'd2,
      KIND_REPORT = 2'd3
   } kind_type;

   // controller to datapath commands, at most one step active at a time
   typedef struct packed {
      logic load;        // capture the accepted item
      logic tick_rd;     // bump lamport clock, read own entry
      logic tick_wr;     // write own entry plus one
      logic merge_rd;    // read the received slot
      logic merge_wr;    // write the maximum back
      logic emit_start;  // read entry 0 into the result register
      logic emit_next;   // read the following entry
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic emit_last;   // result register holds the final entry of the stamp
   } status_type;

endpackage

[src/vlc_ctrl.sv]
// vlc_ctrl: sequencing state machine of the vector/lamport clock block
// depends on vlc_pkg for the kind codes and the command/status structs
module vlc_ctrl import vlc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic                req_first_element,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output cmd_type             cmd,
   input  status_type          status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK_RD,
      ST_TICK_WR,
      ST_MERGE_RD,
      ST_MERGE_WR,
      ST_EMIT_RD,
      ST_EMIT_WAIT
   } state_type;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   kind_type  req_kind_e;

   assign req_kind_e = kind_type'(req_kind);
   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;

   always_comb begin
      cmd            = '0;
      cmd.load       = accept;
      cmd.tick_rd    = (state_ff == ST_TICK_RD);
      cmd.tick_wr    = (state_ff == ST_TICK_WR);
      cmd.merge_rd   = (state_ff == ST_MERGE_RD);
      cmd.merge_wr   = (state_ff == ST_MERGE_WR);
      cmd.emit_start = (state_ff == ST_EMIT_RD);
      cmd.emit_next  = (state_ff == ST_EMIT_WAIT) && rsp_ready && !status.emit_last;
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      rsp_valid_in = rsp_valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in = req_kind_e;
               unique case (req_kind_e)
                  KIND_LOCAL, KIND_SEND: state_in = ST_TICK_RD;
                  KIND_RECV:   state_in = req_first_element ? ST_TICK_RD : ST_MERGE_RD;
                  KIND_REPORT: state_in = ST_EMIT_RD;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_TICK_RD: state_in = ST_TICK_WR;
         ST_TICK_WR: begin
            unique case (kind_ff)
               KIND_SEND: state_in = ST_EMIT_RD;
               KIND_RECV: state_in = ST_MERGE_RD;
               default:   state_in = ST_IDLE;
            endcase
         end
         ST_MERGE_RD: state_in = ST_MERGE_WR;
         ST_MERGE_WR: state_in = ST_IDLE;
         ST_EMIT_RD: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (rsp_ready && status.emit_last) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kind_ff      <= KIND_LOCAL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[src/vlc_datapath.sv]
// vlc_datapath: clock registers, vector memory, merge and stamp read-out
// depends on vlc_pkg for field widths, register codes and command/status structs
module vlc_datapath import vlc_pkg::*; #(
   parameter int MAX_PROCESSES = DEF_MAX_PROCESSES,
   parameter int CLOCK_WIDTH   = DEF_CLOCK_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic [KIND_W-1:0]      req_kind,
   input  logic                   req_first_element,
   input  logic [SLOT_W-1:0]      req_slot_index,
   input  logic [FIELD_W-1:0]     req_slot_value,
   input  logic [FIELD_W-1:0]     req_sender_lamport,
   output logic [FIELD_W-1:0]     rsp_lamport_stamp,
   output logic [SLOT_W-1:0]      rsp_stamp_slot,
   output logic [FIELD_W-1:0]     rsp_stamp_value,
   output logic                   rsp_last_of_run,
   input  cmd_type                cmd,
   output status_type             status
);

   localparam int AW = $clog2(MAX_PROCESSES);
   localparam int CW = $clog2(MAX_PROCESSES + 1);
   localparam logic [63:0] CLK_MAX64 = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - CLOCK_WIDTH);
   localparam logic [CLOCK_WIDTH-1:0] CLK_MAX = CLOCK_WIDTH'(CLK_MAX64);

   // configuration registers
   logic [OWN_W-1:0] own_ff;
   logic [ACT_W-1:0] act_ff;

   // captured item
   logic [SLOT_W-1:0]      slot_ff;
   logic [CLOCK_WIDTH-1:0] value_ff, value_in;
   logic [CLOCK_WIDTH-1:0] cand_ff, cand_in, sender_clamp;
   logic                   first_ff;

   logic [CLOCK_WIDTH-1:0] lamport_ff, lamport_in, lamport_inc;

   // vector memory with per-entry valid bits, entries never written read as zero
   logic [CLOCK_WIDTH-1:0] mem [MAX_PROCESSES];
   logic [MAX_PROCESSES-1:0] valid_ff;
   logic [CLOCK_WIDTH-1:0] mem_q_ff;
   logic                   mem_valid_q_ff;
   logic [CLOCK_WIDTH-1:0] rd_data;

   logic [AW-1:0]          rd_addr, wr_addr, q_ff;
   logic                   rd_en, wr_en, last_ff;
   logic [CLOCK_WIDTH-1:0] wr_data;

   logic [CW-1:0] count_use;
   logic          own_active, slot_active;

   always_comb begin
      if (act_ff == '0)
         count_use = CW'(1);
      else if (act_ff > ACT_W'(MAX_PROCESSES))
         count_use = CW'(MAX_PROCESSES);
      else
         count_use = CW'(act_ff);
   end

   assign own_active  = ACT_W'(own_ff) < ACT_W'(count_use);
   assign slot_active = ACT_W'(slot_ff) < ACT_W'(count_use);

   // saturate received fields to the clock range
   always_comb begin
      value_in     = (64'(req_slot_value) > CLK_MAX64) ? CLK_MAX
                                                       : CLOCK_WIDTH'(req_slot_value);
      sender_clamp = (64'(req_sender_lamport) > CLK_MAX64) ? CLK_MAX
                                                           : CLOCK_WIDTH'(req_sender_lamport);
      cand_in      = (sender_clamp == CLK_MAX) ? CLK_MAX : sender_clamp + CLOCK_WIDTH'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff <= OWN_INDEX_RESET;
         act_ff <= ACTIVE_COUNT_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_OWN_INDEX)
            own_ff <= csr_wdata[OWN_W-1:0];
         else if (csr_index == CSR_ACTIVE_COUNT)
            act_ff <= csr_wdata[ACT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         slot_ff  <= req_slot_index;
         value_ff <= value_in;
         cand_ff  <= cand_in;
         first_ff <= (kind_type'(req_kind) == KIND_RECV) && req_first_element;
      end
   end

   // lamport clock: tick, then on a first received element take the sender's clock plus one if larger
   always_comb begin
      lamport_inc = (lamport_ff == CLK_MAX) ? CLK_MAX : lamport_ff + CLOCK_WIDTH'(1);
      lamport_in  = lamport_ff;
      if (cmd.tick_rd)
         lamport_in = (first_ff && cand_ff > lamport_inc) ? cand_ff : lamport_inc;
   end

   always_ff @(posedge clock) begin
      if (reset)
         lamport_ff <= '0;
      else
         lamport_ff <= lamport_in;
   end

   // memory port control
   assign rd_data = mem_valid_q_ff ? mem_q_ff : '0;

   always_comb begin
      rd_en   = 1'b1;
      rd_addr = '0;
      priority if (cmd.tick_rd)
         rd_addr = own_ff[AW-1:0];
      else if (cmd.merge_rd)
         rd_addr = slot_ff[AW-1:0];
      else if (cmd.emit_start)
         rd_addr = '0;
      else if (cmd.emit_next)
         rd_addr = q_ff + AW'(1);
      else
         rd_en = 1'b0;
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = own_ff[AW-1:0];
      wr_data = (rd_data == CLK_MAX) ? CLK_MAX : rd_data + CLOCK_WIDTH'(1);
      priority if (cmd.tick_wr) begin
         wr_en = own_active;
      end else if (cmd.merge_wr) begin
         wr_addr = slot_ff[AW-1:0];
         wr_data = value_ff;
         wr_en   = slot_active && (value_ff > rd_data);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      if (rd_en) begin
         mem_q_ff       <= mem[rd_addr];
         mem_valid_q_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= '0;
      else if (wr_en)
         valid_ff[wr_addr] <= 1'b1;
   end

   // stamp position of the entry in the result register
   always_ff @(posedge clock) begin
      if (cmd.emit_start || cmd.emit_next) begin
         q_ff    <= rd_addr;
         last_ff <= (CW'(rd_addr) + CW'(1)) == count_use;
      end
   end

   assign status.emit_last  = last_ff;
   assign rsp_lamport_stamp = FIELD_W'(lamport_ff);
   assign rsp_stamp_slot    = SLOT_W'(q_ff);
   assign rsp_stamp_value   = FIELD_W'(rd_data);
   assign rsp_last_of_run   = last_ff;

endmodule

[src/vector_lamport_clock_core.sv]
// vector_lamport_clock_core: top level of the vector and lamport clock block
// depends on vlc_pkg, vlc_ctrl and vlc_datapath
//
// usage
//  - req channel: one item per event; kind selects local event, send,
//    received vector element or report; ready is high only while idle
//  - rsp channel: a send or report item returns one item per active vector
//    entry (slot 0 upward), each with the lamport clock; last_of_run marks
//    the final entry
//  - csr channel: register 0 own_index, register 1 active_count; always
//    ready, write only while no item is in flight
//  - steps per item, set by the single-port vector memory with registered
//    read (read then write-back for every update):
//      local event: tick read, tick write; non-first received element:
//      merge read, merge write; first received element: tick then merge
//      report: entry 0 read into the result register, then one entry per
//      cycle while rsp_ready is high; send adds the tick steps in front
//  - a stalled receiver holds the current entry; the next one is read only
//    after it is taken, and no new item is accepted until the last is taken
//  - reset: lamport clock zero, all vector entries read as zero through
//    per-entry valid bits, own_index 1, active_count 16; no clearing pass
module vector_lamport_clock_core import vlc_pkg::*; #(
   parameter int MAX_PROCESSES = DEF_MAX_PROCESSES,
   parameter int CLOCK_WIDTH   = DEF_CLOCK_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // event items
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [KIND_W-1:0]      req_kind,
   input  logic                   req_first_element,
   input  logic [SLOT_W-1:0]      req_slot_index,
   input  logic [FIELD_W-1:0]     req_slot_value,
   input  logic [FIELD_W-1:0]     req_sender_lamport,
   // stamp items
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [FIELD_W-1:0]     rsp_lamport_stamp,
   output logic [SLOT_W-1:0]      rsp_stamp_slot,
   output logic [FIELD_W-1:0]     rsp_stamp_value,
   output logic                   rsp_last_of_run
);

   cmd_type    cmd;
   status_type status;

   // register writes never stall
   assign csr_ready = 1'b1;

   // sequencer: one item at a time
   vlc_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_first_element (req_first_element),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .cmd               (cmd),
      .status            (status)
   );

   // clocks, vector memory and stamp register
   vlc_datapath #(
      .MAX_PROCESSES (MAX_PROCESSES),
      .CLOCK_WIDTH   (CLOCK_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_kind           (req_kind),
      .req_first_element  (req_first_element),
      .req_slot_index     (req_slot_index),
      .req_slot_value     (req_slot_value),
      .req_sender_lamport (req_sender_lamport),
      .rsp_lamport_stamp  (rsp_lamport_stamp),
      .rsp_stamp_slot     (rsp_stamp_slot),
      .rsp_stamp_value    (rsp_stamp_value),
      .rsp_last_of_run    (rsp_last_of_run),
      .cmd                (cmd),
      .status             (status)
   );

   // no new item while a stamp is still pending
   a_idle_no_stamp: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("req_ready high while a stamp entry is pending");

   // the stamp ends right after its last entry is taken
   a_stamp_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_of_run |=> !rsp_valid)
      else $error("stamp continues past its last entry");

   // entries of one stamp come in consecutive slots
   a_stamp_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=>
         rsp_valid && (rsp_stamp_slot == $past(rsp_stamp_slot) + SLOT_W'(1)))
      else $error("stamp slot did not advance by one");

   // emitted slots stay inside the vector
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (ACT_W'(rsp_stamp_slot) < ACT_W'(MAX_PROCESSES)))
      else $error("stamp slot beyond vector size");

endmodule

[sim/tb_vector_lamport_clock_core.sv]
// tb_vector_lamport_clock_core: self-checking bench for the vector and lamport clock core
// replays an opening script, random traffic under several register settings, then a closing script
// depends on vlc_pkg and vector_lamport_clock_core
module tb_vector_lamport_clock_core;
   import vlc_pkg::*;

   localparam int PROCS       = DEF_MAX_PROCESSES;
   localparam int CW          = DEF_CLOCK_WIDTH;
   localparam int SETTLE      = 8;        // covers the first-element tick and merge
   localparam int LIMIT       = 400000;
   localparam int PHASE_ITEMS = 41;
   localparam int N_PHASES    = 8;
   localparam logic [CW-1:0] CLK_TOP = '1;

   // register indexes with nothing behind them
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_3 = 2'd3;

   // one item of an emitted stamp
   typedef struct {
      logic [FIELD_W-1:0] lamport;
      logic [SLOT_W-1:0]  slot;
      logic [FIELD_W-1:0] value;
      logic               last;
   } stamp_type;

   // one line of the directed script: a register write or an event item
   typedef struct {
      bit                     reg_write;
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [CSR_DATA_W-1:0]  reg_data;
      kind_type               kind;
      logic                   first;
      logic [SLOT_W-1:0]      slot;
      logic [FIELD_W-1:0]     value;
      logic [FIELD_W-1:0]     sender;
      bit                     pinned;        // lamport stamp typed in by hand
      logic [FIELD_W-1:0]     pin_lamport;
   } script_row_type;

   // clock, reset and block ports
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [KIND_W-1:0]      req_kind = '0;
   logic                   req_first_element = 1'b0;
   logic [SLOT_W-1:0]      req_slot_index = '0;
   logic [FIELD_W-1:0]     req_slot_value = '0;
   logic [FIELD_W-1:0]     req_sender_lamport = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b1;
   logic [FIELD_W-1:0]     rsp_lamport_stamp;
   logic [SLOT_W-1:0]      rsp_stamp_slot;
   logic [FIELD_W-1:0]     rsp_stamp_value;
   logic                   rsp_last_of_run;

   // travels with the held item so the monitor knows about typed stamps
   bit                     stamp_pinned = 1'b0;
   logic [FIELD_W-1:0]     pinned_lamport = '0;

   // predicted clocks and registers
   logic [CW-1:0]          lamport_now;
   logic [CW-1:0]          vector_now [PROCS];
   logic [OWN_W-1:0]       own_cfg;
   logic [ACT_W-1:0]       active_cfg;
   stamp_type              pending_stamps [$];

   script_row_type         script [$];
   int unsigned            mismatches = 0;
   int unsigned            items_sent = 0;
   int unsigned            cycle_count = 0;
   int unsigned            rough = 260;     // loose guess of the lamport clock for stimulus
   bit                     calm = 1'b0;     // no idling on either side
   int unsigned            stall_left = 0;
   int unsigned            flow_left = 0;

   logic [CSR_DATA_W-1:0]  phase_own [N_PHASES] = '{7'd0, 7'd63, 7'd15, 7'd69,
                                                   7'd3, 7'd0, 7'd9, 7'd1};
   logic [CSR_DATA_W-1:0]  phase_active [N_PHASES] = '{7'd1, 7'd64, 7'd16, 7'd0,
                                                      7'd7, 7'd127, 7'd12, 7'd16};

   vector_lamport_clock_core dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_first_element  (req_first_element),
      .req_slot_index     (req_slot_index),
      .req_slot_value     (req_slot_value),
      .req_sender_lamport (req_sender_lamport),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_lamport_stamp  (rsp_lamport_stamp),
      .rsp_stamp_slot     (rsp_stamp_slot),
      .rsp_stamp_value    (rsp_stamp_value),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // saturating increment at the clock maximum
   function automatic logic [CW-1:0] bump(logic [CW-1:0] v);
      return (v == CLK_TOP) ? v : v + 1'b1;
   endfunction

   // received values wider than the clock clip to its maximum
   function automatic logic [CW-1:0] fit(logic [FIELD_W-1:0] v);
      return (64'(v) > 64'(CLK_TOP)) ? CLK_TOP : CW'(v);
   endfunction

   // active_count clamped to 1 .. PROCS, zero acting as one
   function automatic int entries_in_use();
      if (active_cfg == 0)
         return 1;
      if (active_cfg > PROCS)
         return PROCS;
      return int'(active_cfg);
   endfunction

   // scalar clock always moves, own entry only while it is active
   task automatic tick_clocks();
      lamport_now = bump(lamport_now);
      if (own_cfg < entries_in_use())
         vector_now[own_cfg] = bump(vector_now[own_cfg]);
   endtask

   // one stamp item per active entry, slot 0 upward, last one marked
   task automatic queue_stamp(bit pinned, logic [FIELD_W-1:0] pin_lamport);
      int n;
      int q;
      stamp_type s;
      n = entries_in_use();
      for (q = 0; q < n; q++) begin
         s.lamport = pinned ? pin_lamport : FIELD_W'(lamport_now);
         s.slot    = SLOT_W'(q);
         s.value   = FIELD_W'(vector_now[q]);
         s.last    = (q == n - 1);
         pending_stamps.push_back(s);
      end
   endtask

   // applies one accepted item to the predicted clocks
   task automatic advance_clocks(kind_type kind, logic first, logic [SLOT_W-1:0] slot,
                                 logic [FIELD_W-1:0] value, logic [FIELD_W-1:0] sender,
                                 bit pinned, logic [FIELD_W-1:0] pin_lamport);
      logic [CW-1:0] cand;
      logic [CW-1:0] merged;
      case (kind)
         KIND_LOCAL: tick_clocks();
         KIND_SEND: begin
            tick_clocks();
            queue_stamp(pinned, pin_lamport);
         end
         KIND_RECV: begin
            // the first element ticks, then pulls the clock up past the sender
            if (first) begin
               cand = bump(fit(sender));
               tick_clocks();
               if (cand > lamport_now)
                  lamport_now = cand;
            end
            // every element merges by maximum, inactive slots drop out
            merged = fit(value);
            if (slot < entries_in_use() && merged > vector_now[slot])
               vector_now[slot] = merged;
         end
         default: queue_stamp(pinned, pin_lamport);
      endcase
   endtask

   task automatic compare_field(string name, logic [FIELD_W-1:0] want,
                                logic [FIELD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // ---------------------------------------------------------------- monitor

   // samples all three handshakes at the edge, before the block updates
   always @(posedge clock) begin
      stamp_type want;
      if (reset) begin
         lamport_now = '0;
         foreach (vector_now[i])
            vector_now[i] = '0;
         own_cfg    = OWN_INDEX_RESET;
         active_cfg = ACTIVE_COUNT_RESET;
      end else begin
         if (csr_valid && csr_ready === 1'b1) begin
            if (csr_index == CSR_OWN_INDEX)
               own_cfg = OWN_W'(csr_wdata);
            else if (csr_index == CSR_ACTIVE_COUNT)
               active_cfg = csr_wdata;
         end
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (pending_stamps.size() == 0) begin
               $display("%0t: stamp item mismatch, expected none, actual slot %0d value %0h",
                        $time, rsp_stamp_slot, rsp_stamp_value);
               mismatches++;
            end else begin
               want = pending_stamps.pop_front();
               compare_field("lamport_stamp", want.lamport, rsp_lamport_stamp);
               compare_field("stamp_slot", FIELD_W'(want.slot), FIELD_W'(rsp_stamp_slot));
               compare_field("stamp_value", want.value, rsp_stamp_value);
               compare_field("last_of_run", FIELD_W'(want.last), FIELD_W'(rsp_last_of_run));
            end
         end
         if (req_valid && req_ready === 1'b1)
            advance_clocks(kind_type'(req_kind), req_first_element, req_slot_index,
                           req_slot_value, req_sender_lamport, stamp_pinned, pinned_lamport);
      end
   end

   // ---------------------------------------------------------------- receiver

   // random stalls of rsp_ready between runs in which it is held high
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (flow_left != 0) begin
         flow_left <= flow_left - 1;
         rsp_ready <= 1'b1;
      end else if ($urandom_range(0, 1) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 8);
         flow_left  <= $urandom_range(1, 30);
      end else begin
         flow_left <= $urandom_range(1, 30);
      end
   end

   // run limit
   always @(posedge clock)
      cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count == LIMIT);
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------- sender

   // holds one item until taken, then at random, unless calm, leaves a gap before the next
   task automatic offer(kind_type k, logic f, logic [SLOT_W-1:0] s, logic [FIELD_W-1:0] v,
                        logic [FIELD_W-1:0] snd, bit pinned, logic [FIELD_W-1:0] pl);
      req_valid          <= 1'b1;
      req_kind           <= k;
      req_first_element  <= f;
      req_slot_index     <= s;
      req_slot_value     <= v;
      req_sender_lamport <= snd;
      stamp_pinned       <= pinned;
      pinned_lamport     <= pl;
      @(posedge clock);
      while (req_ready !== 1'b1)
         @(posedge clock);
      items_sent++;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // stop sending until every stamp is back and any merge has finished
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_stamps.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // register writes only ever happen on an idle block
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (csr_ready !== 1'b1)
         @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic script_row_type item_row(kind_type k, logic f, logic [SLOT_W-1:0] s,
                                               logic [FIELD_W-1:0] v,
                                               logic [FIELD_W-1:0] snd);
      script_row_type r;
      r.reg_write   = 1'b0;
      r.reg_index   = '0;
      r.reg_data    = '0;
      r.kind        = k;
      r.first       = f;
      r.slot        = s;
      r.value       = v;
      r.sender      = snd;
      r.pinned      = 1'b0;
      r.pin_lamport = '0;
      return r;
   endfunction

   function automatic script_row_type reg_row(logic [CSR_INDEX_W-1:0] idx,
                                              logic [CSR_DATA_W-1:0] data);
      script_row_type r;
      r = item_row(KIND_LOCAL, 1'b0, '0, '0, '0);
      r.reg_write = 1'b1;
      r.reg_index = idx;
      r.reg_data  = data;
      return r;
   endfunction

   function automatic script_row_type with_lamport(script_row_type r,
                                                   logic [FIELD_W-1:0] l);
      r.pinned      = 1'b1;
      r.pin_lamport = l;
      return r;
   endfunction

   task automatic play_rows(int unsigned lo, int unsigned hi);
      int unsigned i;
      for (i = lo; i < hi; i++) begin
         if (script[i].reg_write)
            write_reg(script[i].reg_index, script[i].reg_data);
         else
            offer(script[i].kind, script[i].first, script[i].slot, script[i].value,
                  script[i].sender, script[i].pinned, script[i].pin_lamport);
      end
   endtask

   // vector values close to the running clock so merges go both ways
   function automatic logic [FIELD_W-1:0] near_value();
      return FIELD_W'(rough - 6 + $urandom_range(0, 12));
   endfunction

   // mostly whole messages, with sends, reports, local events and some junk
   task automatic random_traffic(int unsigned quota);
      int unsigned start;
      int unsigned pick;
      int unsigned extra;
      int n;
      kind_type k;
      logic f;
      logic [FIELD_W-1:0] snd;
      start = items_sent;
      n = entries_in_use();
      while (items_sent - start < quota) begin
         pick = $urandom_range(0, 99);
         rough++;
         if (pick < 55) begin
            // a received message, now and then missing its first element
            snd = FIELD_W'(rough + $urandom_range(0, 40));
            if ($urandom_range(0, 7) != 0) begin
               offer(KIND_RECV, 1'b1, SLOT_W'($urandom_range(0, n - 1)), near_value(), snd,
                     1'b0, '0);
               if (snd >= rough)
                  rough = snd + 1;
            end
            extra = $urandom_range(0, n - 1);
            repeat (extra)
               offer(KIND_RECV, 1'b0, SLOT_W'($urandom_range(0, n - 1)), near_value(),
                     $urandom(), 1'b0, '0);
         end else if (pick < 70) begin
            offer(KIND_SEND, 1'($urandom_range(0, 1)), SLOT_W'($urandom_range(0, 63)),
                  $urandom(), $urandom(), 1'b0, '0);
         end else if (pick < 80) begin
            offer(KIND_REPORT, 1'($urandom_range(0, 1)), SLOT_W'($urandom_range(0, 63)),
                  $urandom(), $urandom(), 1'b0, '0);
         end else if (pick < 92) begin
            offer(KIND_LOCAL, 1'($urandom_range(0, 1)), SLOT_W'($urandom_range(0, 63)),
                  $urandom(), $urandom(), 1'b0, '0);
         end else begin
            // junk over the whole field ranges, but a first element never saturates
            k = kind_type'($urandom_range(0, 3));
            f = 1'($urandom_range(0, 1));
            snd = (k == KIND_RECV && f) ? FIELD_W'(rough + $urandom_range(0, 9)) : $urandom();
            offer(k, f, SLOT_W'($urandom_range(0, 63)), $urandom(), snd, 1'b0, '0);
         end
         if (!calm && $urandom_range(0, 39) == 0)
            drain();
      end
   endtask

   // ---------------------------------------------------------------- main sequence

   initial begin
      int unsigned p;
      int unsigned opening;

      // opening script, reset settings: own slot 1, sixteen entries
      script.push_back(with_lamport(item_row(KIND_REPORT, 1'b0, 0, 0, 0), 0));
      script.push_back(item_row(KIND_LOCAL, 1'b0, 0, 0, 0));
      script.push_back(with_lamport(item_row(KIND_SEND, 1'b0, 0, 0, 0), 2));
      script.push_back(item_row(KIND_RECV, 1'b1, 0, 5, 9));
      // later elements ignore their sender field
      script.push_back(item_row(KIND_RECV, 1'b0, 1, 1, 'hFFFF_FFFF));
      script.push_back(item_row(KIND_RECV, 1'b0, 15, 7, 0));
      // slots past the active count merge nothing
      script.push_back(item_row(KIND_RECV, 1'b0, 16, 'h1234, 0));
      script.push_back(item_row(KIND_RECV, 1'b0, 63, 'hFFFF_FFFF, 0));
      script.push_back(with_lamport(item_row(KIND_REPORT, 1'b0, 0, 0, 0), 10));
      // first flag means nothing outside received elements
      script.push_back(item_row(KIND_LOCAL, 1'b1, 63, 'hFFFF_FFFF, 'hFFFF_FFFF));
      script.push_back(with_lamport(item_row(KIND_SEND, 1'b1, 63, 'hFFFF_FFFF,
                                             'hFFFF_FFFF), 12));
      script.push_back(with_lamport(item_row(KIND_REPORT, 1'b1, 63, 'hFFFF_FFFF,
                                             'hFFFF_FFFF), 12));
      // sender behind the local clock: tick only
      script.push_back(item_row(KIND_RECV, 1'b1, 2, 0, 0));
      script.push_back(reg_row(CSR_UNMAPPED_2, 7'h7F));
      script.push_back(reg_row(CSR_UNMAPPED_3, 7'h55));
      script.push_back(with_lamport(item_row(KIND_REPORT, 1'b0, 0, 0, 0), 13));
      // one active entry, own slot 0
      script.push_back(reg_row(CSR_OWN_INDEX, 7'd0));
      script.push_back(reg_row(CSR_ACTIVE_COUNT, 7'd1));
      script.push_back(with_lamport(item_row(KIND_REPORT, 1'b0, 0, 0, 0), 13));
      script.push_back(item_row(KIND_LOCAL, 1'b0, 0, 0, 0));
      script.push_back(item_row(KIND_RECV, 1'b1, 1, 50, 100));
      // zero entries acts as one
      script.push_back(reg_row(CSR_ACTIVE_COUNT, 7'd0));
      script.push_back(with_lamport(item_row(KIND_REPORT, 1'b0, 0, 0, 0), 101));
      // own slot outside the active entries
      script.push_back(reg_row(CSR_OWN_INDEX, 7'd63));
      script.push_back(item_row(KIND_LOCAL, 1'b0, 0, 0, 0));
      script.push_back(with_lamport(item_row(KIND_REPORT, 1'b0, 0, 0, 0), 102));
      // count above the vector size clamps to sixteen
      script.push_back(reg_row(CSR_ACTIVE_COUNT, 7'd127));
      script.push_back(item_row(KIND_RECV, 1'b1, 15, 20, 200));
      script.push_back(with_lamport(item_row(KIND_SEND, 1'b0, 0, 0, 0), 202));
      opening = script.size();

      // closing script: drive both clocks into saturation
      script.push_back(reg_row(CSR_OWN_INDEX, 7'd2));
      script.push_back(reg_row(CSR_ACTIVE_COUNT, 7'd16));
      script.push_back(item_row(KIND_RECV, 1'b1, 2, 'hFFFF_FFFF, 'hFFFF_FFFE));
      script.push_back(item_row(KIND_LOCAL, 1'b0, 0, 0, 0));
      script.push_back(with_lamport(item_row(KIND_REPORT, 1'b0, 0, 0, 0), 'hFFFF_FFFF));
      script.push_back(item_row(KIND_RECV, 1'b1, 3, 'h8000_0000, 'hFFFF_FFFF));
      script.push_back(with_lamport(item_row(KIND_SEND, 1'b0, 0, 0, 0), 'hFFFF_FFFF));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      play_rows(0, opening);

      // random traffic under each register setting, the last phase without idling
      for (p = 0; p < N_PHASES; p++) begin
         write_reg(CSR_OWN_INDEX, phase_own[p]);
         write_reg(CSR_ACTIVE_COUNT, phase_active[p]);
         calm = (p == N_PHASES - 1);
         random_traffic(PHASE_ITEMS);
      end

      play_rows(opening, script.size());
      drain();

      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
